// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, constants and helpers shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int PAGE_BYTES    = 4096;
  localparam int MAX_PAGES     = 16;
  localparam int GRANULE_BYTES = 16;

  localparam int GRAN_SHIFT   = $clog2(GRANULE_BYTES);
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int PAGE_G       = PAGE_BYTES / GRANULE_BYTES;
  localparam int PAGE_G_SHIFT = $clog2(PAGE_G);
  localparam int HDR_DEPTH    = MAX_PAGES * PAGE_G;
  localparam int IDX_W        = $clog2(HDR_DEPTH);
  localparam int SIZE_W       = IDX_W + 1;
  localparam int PAGES_W      = $clog2(MAX_PAGES) + 1;
  localparam int HDR_G        = 2;
  localparam int MIN_G        = 1;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int ADDR_W       = 16;
  localparam int REQ_W        = 17;
  localparam int BYTES_W      = 17;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  next;
    logic              next_ok;
    logic              is_free;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_OUT_OF_MEM  = 2'd1,
    ST_BAD_ADDR    = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_CHK_RD,
    S_FF_START,
    S_FF_CHK,
    S_FF_RD,
    S_FF_WREM,
    S_FF_WPREV,
    S_FF_WCUR,
    S_FF_END,
    S_GROW,
    S_INS_START,
    S_INS_CHK,
    S_INS_RD,
    S_INS_CURRD,
    S_INS_MERGE,
    S_INS_WB,
    S_INS_WP,
    S_DONE
  } state_e;

  function automatic logic [BYTES_W-1:0] g2b(logic [SIZE_W-1:0] g);
    return BYTES_W'({g, {GRAN_SHIFT{1'b0}}});
  endfunction

endpackage

// ===== rtl/ffha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with an address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
// Requests are handled one at a time and every request returns one result.
// All block headers live in a single-port header RAM with a registered read,
// so each free-list entry visited takes a check state and a read state. A
// heap growth adds one insertion walk and a second search, and a moving
// reallocate adds a free after the allocate. A new request is taken as soon
// as the previous result is in the output register.
module first_fit_heap_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ffha_pkg::CMD_W-1:0]      cmd_i,
  input  logic [ffha_pkg::REQ_W-1:0]      req_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]     block_addr_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ffha_pkg::ADDR_W-1:0]     result_addr_o,
  output logic [ffha_pkg::STATUS_W-1:0]   status_o,
  output logic [ffha_pkg::BYTES_W-1:0]    used_bytes_o,
  output logic [ffha_pkg::BYTES_W-1:0]    free_bytes_o,
  output logic [ffha_pkg::BYTES_W-1:0]    total_bytes_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ffha_pkg::PAGES_W-1:0]    cfg_data_i
);

  import ffha_pkg::*;

  state_e state_q, state_d;

  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [SIZE_W-1:0]  need_q, need_d;
  logic               size_zero_q, size_zero_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;

  logic [IDX_W-1:0]   head_q, head_d;
  logic               head_ok_q, head_ok_d;
  logic [PAGES_W-1:0] pages_q, pages_d;
  logic [BYTES_W-1:0] live_q, live_d;
  logic [BYTES_W-1:0] freep_q, freep_d;
  logic [PAGES_W-1:0] budget_q, budget_d;

  logic [IDX_W-1:0]   cur_q, cur_d;
  logic               cur_ok_q, cur_ok_d;
  logic [IDX_W-1:0]   prev_q, prev_d;
  logic               prev_ok_q, prev_ok_d;
  hdr_t               prevh_q, prevh_d;
  hdr_t               curh_q, curh_d;
  logic [IDX_W:0]     steps_q, steps_d;
  logic [IDX_W-1:0]   b_q, b_d;
  logic [SIZE_W-1:0]  b_size_q, b_size_d;
  logic [SIZE_W-1:0]  old_size_q, old_size_d;
  logic [IDX_W-1:0]   blk_q, blk_d;
  logic               split_q, split_d;
  logic [IDX_W-1:0]   rem_q, rem_d;
  hdr_t               wb_q, wb_d;
  hdr_t               wp_q, wp_d;
  logic               grown_q, grown_d;
  logic               retry_q, retry_d;
  logic               realloc_q, realloc_d;
  logic [ADDR_W-1:0]  res_q, res_d;
  status_e            st_q, st_d;

  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  status_e            out_st_q, out_st_d;
  logic [BYTES_W-1:0] out_used_q, out_used_d;
  logic [BYTES_W-1:0] out_free_q, out_free_d;
  logic [BYTES_W-1:0] out_total_q, out_total_d;

  logic [IDX_W-1:0]   ram_addr;
  logic               ram_we;
  hdr_t               ram_wdata;
  logic [HDR_W-1:0]   ram_rdata;
  hdr_t               rd_hdr;

  logic                 accept;
  logic                 out_free_slot;
  logic                 walk_go;
  logic                 ins_go;
  logic                 fit;
  logic [BYTES_W-1:0]   total_bytes;
  logic                 addr_bad;
  logic [IDX_W-1:0]     blk_calc;
  logic [REQ_W:0]       need_sum;
  logic [PAGES_W-1:0]   limit;
  logic                 grow_ok;
  logic [SIZE_W:0]      grow_sum;
  logic [SIZE_W-PAGE_G_SHIFT:0] grow_pages;
  logic [PAGES_W-1:0]   grow_avail;
  logic [PAGES_W-1:0]   grow_n;
  logic [SIZE_W-1:0]    grow_g;
  logic [SIZE_W-1:0]    ff_remain;
  logic                 ff_split;
  logic [SIZE_W-1:0]    ff_newsize;
  logic [SIZE_W:0]      need_hdr;
  logic [SIZE_W:0]      b_end;
  logic [SIZE_W:0]      p_end;
  logic                 mc;
  logic                 mp;
  logic [SIZE_W-1:0]    m_bsz;
  logic [IDX_W-1:0]     m_bnext;
  logic                 m_bok;

  assign rd_hdr        = hdr_t'(ram_rdata);
  assign accept        = in_valid_i && !in_stall_o;
  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free_slot = !out_valid_q || !out_stall_i;

  assign walk_go     = cur_ok_q && !steps_q[IDX_W];
  assign ins_go      = walk_go && (cur_q < b_q);
  assign fit         = rd_hdr.size >= need_q;
  assign total_bytes = BYTES_W'({pages_q, {PAGE_SHIFT{1'b0}}});
  assign addr_bad    = (addr_q < ADDR_W'(HDR_G * GRANULE_BYTES))
                    || (addr_q[GRAN_SHIFT-1:0] != '0)
                    || ({1'b0, addr_q} >= total_bytes);
  assign blk_calc    = addr_q[ADDR_W-1:GRAN_SHIFT] - IDX_W'(HDR_G);
  assign need_sum    = {1'b0, req_size_i} + (REQ_W+1)'(GRANULE_BYTES - 1);

  assign limit      = (budget_q > PAGES_W'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES) : budget_q;
  assign grow_ok    = pages_q < limit;
  assign grow_sum   = {1'b0, need_q} + (SIZE_W+1)'(HDR_G + PAGE_G - 1);
  assign grow_pages = grow_sum[SIZE_W:PAGE_G_SHIFT];
  assign grow_avail = limit - pages_q;
  assign grow_n     = ({1'b0, grow_avail} > grow_pages) ? grow_pages[PAGES_W-1:0] : grow_avail;
  assign grow_g     = SIZE_W'({grow_n, {PAGE_G_SHIFT{1'b0}}});

  assign ff_remain  = rd_hdr.size - need_q;
  assign ff_split   = ff_remain >= SIZE_W'(HDR_G + MIN_G);
  assign ff_newsize = ff_split ? need_q : rd_hdr.size;
  assign need_hdr   = {1'b0, need_q} + (SIZE_W+1)'(HDR_G);

  assign b_end   = {1'b0, b_q} + (SIZE_W+1)'(HDR_G) + {1'b0, b_size_q};
  assign mc      = cur_ok_q && (b_end == (SIZE_W+1)'(cur_q));
  assign m_bsz   = mc ? (b_size_q + SIZE_W'(HDR_G) + curh_q.size) : b_size_q;
  assign m_bnext = mc ? curh_q.next : cur_q;
  assign m_bok   = mc ? curh_q.next_ok : cur_ok_q;
  assign p_end   = {1'b0, prev_q} + (SIZE_W+1)'(HDR_G) + {1'b0, prevh_q.size};
  assign mp      = prev_ok_q && (p_end == (SIZE_W+1)'(b_q));

  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HDR_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cmd_e'(cmd_q))
          CMD_ALLOC:   state_d = size_zero_q ? S_DONE : S_FF_START;
          CMD_FREE:    state_d = (addr_q == '0) ? S_DONE : S_CHECK;
          CMD_REALLOC: begin
            if (addr_q == '0) begin
              state_d = size_zero_q ? S_DONE : S_FF_START;
            end else begin
              state_d = S_CHECK;
            end
          end
          default:     state_d = S_DONE;
        endcase
      end
      S_CHECK:     state_d = addr_bad ? S_DONE : S_CHK_RD;
      S_CHK_RD: begin
        if (rd_hdr.is_free) begin
          state_d = S_DONE;
        end else if (realloc_q) begin
          state_d = (need_q <= rd_hdr.size) ? S_DONE : S_FF_START;
        end else begin
          state_d = S_INS_START;
        end
      end
      S_FF_START:  state_d = S_FF_CHK;
      S_FF_CHK: begin
        if (walk_go) begin
          state_d = S_FF_RD;
        end else if (!grown_q) begin
          state_d = S_GROW;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FF_RD:     state_d = fit ? S_FF_WREM : S_FF_CHK;
      S_FF_WREM:   state_d = S_FF_WPREV;
      S_FF_WPREV:  state_d = S_FF_WCUR;
      S_FF_WCUR:   state_d = S_FF_END;
      S_FF_END: begin
        state_d = (realloc_q && (res_q != '0)) ? S_INS_START : S_DONE;
      end
      S_GROW:      state_d = grow_ok ? S_INS_START : S_DONE;
      S_INS_START: state_d = S_INS_CHK;
      S_INS_CHK: begin
        if (ins_go) begin
          state_d = S_INS_RD;
        end else if (cur_ok_q) begin
          state_d = S_INS_CURRD;
        end else begin
          state_d = S_INS_MERGE;
        end
      end
      S_INS_RD:    state_d = S_INS_CHK;
      S_INS_CURRD: state_d = S_INS_MERGE;
      S_INS_MERGE: state_d = S_INS_WB;
      S_INS_WB:    state_d = S_INS_WP;
      S_INS_WP:    state_d = retry_q ? S_FF_START : S_DONE;
      S_DONE: begin
        if (out_free_slot) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_addr  = cur_q;
    ram_we    = 1'b0;
    ram_wdata = wb_q;
    unique case (state_q)
      S_CHECK:    ram_addr = blk_calc;
      S_FF_WREM: begin
        ram_addr = rem_q;
        ram_we   = split_q;
      end
      S_FF_WPREV: begin
        ram_addr  = prev_q;
        ram_we    = prev_ok_q;
        ram_wdata = wp_q;
      end
      S_FF_WCUR: begin
        ram_we    = 1'b1;
        ram_wdata = curh_q;
      end
      S_INS_WB: begin
        ram_addr = b_q;
        ram_we   = 1'b1;
      end
      S_INS_WP: begin
        ram_addr  = prev_q;
        ram_we    = prev_ok_q;
        ram_wdata = wp_q;
      end
      default: begin
        ram_addr = cur_q;
      end
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    need_d      = need_q;
    size_zero_d = size_zero_q;
    addr_d      = addr_q;
    head_d      = head_q;
    head_ok_d   = head_ok_q;
    pages_d     = pages_q;
    live_d      = live_q;
    freep_d     = freep_q;
    budget_d    = budget_q;
    cur_d       = cur_q;
    cur_ok_d    = cur_ok_q;
    prev_d      = prev_q;
    prev_ok_d   = prev_ok_q;
    prevh_d     = prevh_q;
    curh_d      = curh_q;
    steps_d     = steps_q;
    b_d         = b_q;
    b_size_d    = b_size_q;
    old_size_d  = old_size_q;
    blk_d       = blk_q;
    split_d     = split_q;
    rem_d       = rem_q;
    wb_d        = wb_q;
    wp_d        = wp_q;
    grown_d     = grown_q;
    retry_d     = retry_q;
    realloc_d   = realloc_q;
    res_d       = res_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    out_used_d  = out_used_q;
    out_free_d  = out_free_q;
    out_total_d = out_total_q;

    if (cfg_valid_i && cfg_ready_o) begin
      budget_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d       = cmd_i;
          need_d      = need_sum[GRAN_SHIFT+SIZE_W-1:GRAN_SHIFT];
          size_zero_d = (req_size_i == '0);
          addr_d      = block_addr_i;
        end
      end
      S_DISPATCH: begin
        res_d     = '0;
        st_d      = ST_OK;
        grown_d   = 1'b0;
        retry_d   = 1'b0;
        realloc_d = (cmd_e'(cmd_q) == CMD_REALLOC) && (addr_q != '0) && !size_zero_q;
      end
      S_CHECK: begin
        blk_d = blk_calc;
        if (addr_bad) st_d = ST_BAD_ADDR;
      end
      S_CHK_RD: begin
        old_size_d = rd_hdr.size;
        if (rd_hdr.is_free) begin
          st_d = ST_DOUBLE_FREE;
        end else if (realloc_q) begin
          if (need_q <= rd_hdr.size) res_d = addr_q;
        end else begin
          b_d      = blk_q;
          b_size_d = rd_hdr.size;
          live_d   = live_q - g2b(rd_hdr.size);
          freep_d  = freep_q + g2b(rd_hdr.size);
        end
      end
      S_FF_START, S_INS_START: begin
        cur_d     = head_q;
        cur_ok_d  = head_ok_q;
        prev_ok_d = 1'b0;
        steps_d   = '0;
      end
      S_FF_CHK: begin
        if (!walk_go && grown_q) begin
          st_d  = ST_OUT_OF_MEM;
          res_d = '0;
        end
      end
      S_FF_RD: begin
        if (fit) begin
          split_d     = ff_split;
          rem_d       = cur_q + IDX_W'(HDR_G) + need_q[IDX_W-1:0];
          wb_d        = '{size: ff_remain - SIZE_W'(HDR_G), next: rd_hdr.next,
                          next_ok: rd_hdr.next_ok, is_free: 1'b1};
          wp_d        = prevh_q;
          wp_d.next   = ff_split ? (cur_q + IDX_W'(HDR_G) + need_q[IDX_W-1:0]) : rd_hdr.next;
          wp_d.next_ok = ff_split ? 1'b1 : rd_hdr.next_ok;
          curh_d      = '{size: ff_newsize, next: '0, next_ok: 1'b0, is_free: 1'b0};
          freep_d     = freep_q - (ff_split ? g2b(need_hdr[SIZE_W-1:0]) : g2b(rd_hdr.size));
          live_d      = live_q + g2b(ff_newsize);
          res_d       = {cur_q + IDX_W'(HDR_G), {GRAN_SHIFT{1'b0}}};
        end else begin
          prev_d    = cur_q;
          prev_ok_d = 1'b1;
          prevh_d   = rd_hdr;
          cur_d     = rd_hdr.next;
          cur_ok_d  = rd_hdr.next_ok;
          steps_d   = steps_q + 1'b1;
        end
      end
      S_FF_WPREV: begin
        if (!prev_ok_q) begin
          head_d    = wp_q.next;
          head_ok_d = wp_q.next_ok;
        end
      end
      S_FF_END: begin
        if (realloc_q) begin
          if (res_q == '0) begin
            st_d = ST_OUT_OF_MEM;
          end else begin
            b_d      = blk_q;
            b_size_d = old_size_q;
            live_d   = live_q - g2b(old_size_q);
            freep_d  = freep_q + g2b(old_size_q);
            retry_d  = 1'b0;
          end
        end
      end
      S_GROW: begin
        if (grow_ok) begin
          pages_d  = pages_q + grow_n;
          b_d      = {pages_q[IDX_W-PAGE_G_SHIFT-1:0], {PAGE_G_SHIFT{1'b0}}};
          b_size_d = grow_g - SIZE_W'(HDR_G);
          freep_d  = freep_q + g2b(grow_g - SIZE_W'(HDR_G));
          grown_d  = 1'b1;
          retry_d  = 1'b1;
        end else begin
          st_d  = ST_OUT_OF_MEM;
          res_d = '0;
        end
      end
      S_INS_RD: begin
        prev_d    = cur_q;
        prev_ok_d = 1'b1;
        prevh_d   = rd_hdr;
        cur_d     = rd_hdr.next;
        cur_ok_d  = rd_hdr.next_ok;
        steps_d   = steps_q + 1'b1;
      end
      S_INS_CURRD: begin
        curh_d = rd_hdr;
      end
      S_INS_MERGE: begin
        wb_d    = '{size: m_bsz, next: m_bnext, next_ok: m_bok, is_free: 1'b1};
        wp_d    = '{size: mp ? (prevh_q.size + SIZE_W'(HDR_G) + m_bsz) : prevh_q.size,
                    next: mp ? m_bnext : b_q, next_ok: mp ? m_bok : 1'b1,
                    is_free: prevh_q.is_free};
        freep_d = freep_q + (mc ? BYTES_W'(HDR_G * GRANULE_BYTES) : '0)
                          + (mp ? BYTES_W'(HDR_G * GRANULE_BYTES) : '0);
      end
      S_INS_WP: begin
        if (!prev_ok_q) begin
          head_d    = b_q;
          head_ok_d = 1'b1;
        end
        retry_d = 1'b0;
      end
      S_DONE: begin
        if (out_free_slot) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_q;
          out_st_d    = st_q;
          out_used_d  = live_q;
          out_free_d  = freep_q;
          out_total_d = total_bytes;
        end
      end
      default: begin
        steps_d = steps_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      head_ok_q   <= 1'b0;
      pages_q     <= '0;
      live_q      <= '0;
      freep_q     <= '0;
      budget_q    <= PAGES_W'(MAX_PAGES);
      out_valid_q <= 1'b0;
      grown_q     <= 1'b0;
      retry_q     <= 1'b0;
      realloc_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      head_ok_q   <= head_ok_d;
      pages_q     <= pages_d;
      live_q      <= live_d;
      freep_q     <= freep_d;
      budget_q    <= budget_d;
      out_valid_q <= out_valid_d;
      grown_q     <= grown_d;
      retry_q     <= retry_d;
      realloc_q   <= realloc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    need_q      <= need_d;
    size_zero_q <= size_zero_d;
    addr_q      <= addr_d;
    cur_q       <= cur_d;
    cur_ok_q    <= cur_ok_d;
    prev_q      <= prev_d;
    prev_ok_q   <= prev_ok_d;
    prevh_q     <= prevh_d;
    curh_q      <= curh_d;
    steps_q     <= steps_d;
    b_q         <= b_d;
    b_size_q    <= b_size_d;
    old_size_q  <= old_size_d;
    blk_q       <= blk_d;
    split_q     <= split_d;
    rem_q       <= rem_d;
    wb_q        <= wb_d;
    wp_q        <= wp_d;
    res_q       <= res_d;
    st_q        <= st_d;
    out_addr_q  <= out_addr_d;
    out_st_q    <= out_st_d;
    out_used_q  <= out_used_d;
    out_free_q  <= out_free_d;
    out_total_q <= out_total_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_addr_q;
  assign status_o      = out_st_q;
  assign used_bytes_o  = out_used_q;
  assign free_bytes_o  = out_free_q;
  assign total_bytes_o = out_total_q;

endmodule
